// ----- sv/hslm_pkg.sv -----
package hslm_pkg;

   // One restoring step per stage for an 8-bit quotient
   localparam int unsigned DivSteps  = 8;
   // Front stage, divider stages, finish stage, output stage
   localparam int unsigned NumStages = DivSteps + 3;

   localparam logic [15:0] HueSector = 16'd60;
   localparam logic [8:0]  HueRed    = 9'd0;
   localparam logic [8:0]  HueGreen  = 9'd120;
   localparam logic [8:0]  HueBlue   = 9'd240;
   localparam logic [8:0]  HueWrap   = 9'd360;

   typedef enum logic [2:0] {
      REG_HUE_A   = 3'd0,
      REG_HUE_B   = 3'd1,
      REG_SAT_A   = 3'd2,
      REG_SAT_B   = 3'd3,
      REG_LIGHT_A = 3'd4,
      REG_LIGHT_B = 3'd5,
      REG_CARE    = 3'd6,
      REG_INVERT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [8:0] hue_a;
      logic [8:0] hue_b;
      logic [7:0] sat_a;
      logic [7:0] sat_b;
      logic [7:0] light_a;
      logic [7:0] light_b;
      logic [2:0] care;
      logic       invert;
   } cfg_type;

   typedef struct packed {
      logic [15:0] hue_num;
      logic [7:0]  hue_den;
      logic [15:0] sat_num;
      logic [7:0]  sat_den;
   } div_req_type;

   typedef struct packed {
      logic [8:0] base;
      logic       neg;
      logic       gray;
      logic       black;
      logic [7:0] light;
   } meta_type;

   typedef struct packed {
      logic [7:0] rem;
      logic [7:0] num_lo;
      logic [7:0] quo;
      logic [7:0] den;
   } div_lane_type;

   typedef struct packed {
      logic [7:0] hue_quo;
      logic [7:0] hue_rem;
      logic [7:0] sat_quo;
      meta_type   meta;
   } div_rsp_type;

endpackage

// ----- sv/rgb_to_hsl_range_mask.sv -----
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall  red, green, blue (8 bits each)
// rsp_      out        rsp_valid/rsp_stall  hue (9), saturation (8), lightness (8), in_range (1)
// csr_      in         csr_valid/csr_ready  csr_index (3), csr_wdata (9)
//
// One pixel enters per cycle while req_stall is low; each passes through one front stage,
// eight stages of the two restoring dividers (one quotient bit each), a finish stage
// and the output register.
// Synchronous active-high reset empties the pipeline and loads the register defaults.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up under rsp_stall and req_stall rises only when every stage holds an item.
module rgb_to_hsl_range_mask
   import hslm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [8:0] rsp_hue,
   output logic [7:0] rsp_saturation,
   output logic [7:0] rsp_lightness,
   output logic       rsp_in_range,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [8:0] csr_wdata
);

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] ready;
   cfg_type              cfg;
   div_req_type          div_req;
   meta_type             meta;
   div_rsp_type          div_rsp;

   always_comb begin
      ready[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int k = NumStages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NumStages-1];
   assign csr_ready = 1'b1;

   hslm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hslm_front u_front (
      .clock   (clock),
      .en      (ready[0]),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .div_req (div_req),
      .meta    (meta)
   );

   hslm_div u_div (
      .clock   (clock),
      .en      (ready[DivSteps:1]),
      .div_req (div_req),
      .meta_in (meta),
      .div_rsp (div_rsp)
   );

   hslm_back u_back (
      .clock      (clock),
      .fin_en     (ready[NumStages-2]),
      .out_en     (ready[NumStages-1]),
      .div_rsp    (div_rsp),
      .cfg        (cfg),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .lightness  (rsp_lightness),
      .in_range   (rsp_in_range)
   );

`ifndef NO_ASSERTIONS
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue <= 9'd359))
      else $error("hue out of range");

   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_saturation == 8'd0)) |-> (rsp_hue == 9'd0))
      else $error("gray pixel with nonzero hue");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled with a free stage");
`endif

endmodule

// ----- sv/hslm_csr.sv -----
module hslm_csr
   import hslm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   input  logic [2:0]    csr_index,
   input  logic [8:0]    csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_HUE_A:   cfg_in.hue_a   = csr_wdata;
            REG_HUE_B:   cfg_in.hue_b   = csr_wdata;
            REG_SAT_A:   cfg_in.sat_a   = csr_wdata[7:0];
            REG_SAT_B:   cfg_in.sat_b   = csr_wdata[7:0];
            REG_LIGHT_A: cfg_in.light_a = csr_wdata[7:0];
            REG_LIGHT_B: cfg_in.light_b = csr_wdata[7:0];
            REG_CARE:    cfg_in.care    = csr_wdata[2:0];
            REG_INVERT:  cfg_in.invert  = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_a   <= 9'd0;
         cfg_ff.hue_b   <= 9'd359;
         cfg_ff.sat_a   <= 8'd0;
         cfg_ff.sat_b   <= 8'd255;
         cfg_ff.light_a <= 8'd0;
         cfg_ff.light_b <= 8'd255;
         cfg_ff.care    <= 3'b111;
         cfg_ff.invert  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/hslm_front.sv -----
module hslm_front
   import hslm_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [7:0]  red,
   input  logic [7:0]  green,
   input  logic [7:0]  blue,
   output div_req_type div_req,
   output meta_type    meta
);

   div_req_type div_req_ff;
   div_req_type div_req_in;
   meta_type    meta_ff;
   meta_type    meta_in;

   logic [7:0] mx;
   logic [7:0] mn;
   logic [7:0] d;
   logic [8:0] diff;
   logic [8:0] diff_neg;
   logic [7:0] n_abs;
   logic [8:0] light_sum;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d = mx - mn;

      // first channel equal to the maximum picks the sector
      priority if (red == mx) begin
         diff = {1'b0, green} - {1'b0, blue};
      end else if (green == mx) begin
         diff = {1'b0, blue} - {1'b0, red};
      end else begin
         diff = {1'b0, red} - {1'b0, green};
      end
      diff_neg = 9'd0 - diff;
      n_abs    = diff[8] ? diff_neg[7:0] : diff[7:0];

      priority if (red == mx) begin
         meta_in.base = diff[8] ? HueWrap : HueRed;
      end else if (green == mx) begin
         meta_in.base = HueGreen;
      end else begin
         meta_in.base = HueBlue;
      end

      light_sum     = {1'b0, mx} + {1'b0, mn};
      meta_in.neg   = diff[8];
      meta_in.gray  = (d == 8'd0);
      meta_in.black = (mx == 8'd0);
      meta_in.light = light_sum[8:1];

      div_req_in.hue_num = {8'd0, n_abs} * HueSector;
      div_req_in.hue_den = d;
      div_req_in.sat_num = {d, 8'd0} - {8'd0, d};
      div_req_in.sat_den = mx;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_req_ff <= div_req_in;
         meta_ff    <= meta_in;
      end
   end

   assign div_req = div_req_ff;
   assign meta    = meta_ff;

endmodule

// ----- sv/hslm_div.sv -----
module hslm_div
   import hslm_pkg::*;
(
   input  logic                clock,
   input  logic [DivSteps-1:0] en,
   input  div_req_type         div_req,
   input  meta_type            meta_in,
   output div_rsp_type         div_rsp
);

   div_lane_type hue_ff  [DivSteps];
   div_lane_type sat_ff  [DivSteps];
   meta_type     meta_ff [DivSteps];
   div_lane_type hue_in  [DivSteps];
   div_lane_type sat_in  [DivSteps];
   div_lane_type hue_init;
   div_lane_type sat_init;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   function automatic div_lane_type div_step(input div_lane_type lane);
      logic [8:0]   trial;
      logic         fits;
      logic [8:0]   diff;
      div_lane_type nxt;
      trial      = {lane.rem, lane.num_lo[7]};
      fits       = (trial >= {1'b0, lane.den});
      diff       = trial - {1'b0, lane.den};
      nxt.rem    = fits ? diff[7:0] : trial[7:0];
      nxt.num_lo = {lane.num_lo[6:0], 1'b0};
      nxt.quo    = {lane.quo[6:0], fits};
      nxt.den    = lane.den;
      return nxt;
   endfunction

   always_comb begin
      hue_init.rem    = div_req.hue_num[15:8];
      hue_init.num_lo = div_req.hue_num[7:0];
      hue_init.quo    = 8'd0;
      hue_init.den    = div_req.hue_den;
      sat_init.rem    = div_req.sat_num[15:8];
      sat_init.num_lo = div_req.sat_num[7:0];
      sat_init.quo    = 8'd0;
      sat_init.den    = div_req.sat_den;
      hue_in[0] = div_step(hue_init);
      sat_in[0] = div_step(sat_init);
      for (int k = 1; k < DivSteps; k++) begin
         hue_in[k] = div_step(hue_ff[k-1]);
         sat_in[k] = div_step(sat_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DivSteps; k++) begin
         if (en[k]) begin
            hue_ff[k]  <= hue_in[k];
            sat_ff[k]  <= sat_in[k];
            meta_ff[k] <= (k == 0) ? meta_in : meta_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign div_rsp.hue_quo = hue_ff[DivSteps-1].quo;
   assign div_rsp.hue_rem = hue_ff[DivSteps-1].rem;
   assign div_rsp.sat_quo = sat_ff[DivSteps-1].quo;
   assign div_rsp.meta    = meta_ff[DivSteps-1];

endmodule

// ----- sv/hslm_back.sv -----
module hslm_back
   import hslm_pkg::*;
(
   input  logic        clock,
   input  logic        fin_en,
   input  logic        out_en,
   input  div_rsp_type div_rsp,
   input  cfg_type     cfg,
   output logic [8:0]  hue,
   output logic [7:0]  saturation,
   output logic [7:0]  lightness,
   output logic        in_range
);

   logic [8:0] hue_ff;
   logic [8:0] hue_in;
   logic [7:0] sat_ff;
   logic [7:0] sat_in;
   logic [7:0] light_ff;
   logic [8:0] out_hue_ff;
   logic [7:0] out_sat_ff;
   logic [7:0] out_light_ff;
   logic       out_range_ff;
   logic       out_range_in;
   logic [8:0] ceil_q;
   logic [2:0] pass;

   function automatic logic lies_between(input logic [8:0] x, input logic [8:0] a,
                                         input logic [8:0] b);
      return ((x >= a) && (x <= b)) || ((x >= b) && (x <= a));
   endfunction

   always_comb begin
      // a negative offset takes the floor, so round the quotient up
      ceil_q = {1'b0, div_rsp.hue_quo} + {8'd0, |div_rsp.hue_rem};
      priority if (div_rsp.meta.gray) begin
         hue_in = 9'd0;
      end else if (div_rsp.meta.neg) begin
         hue_in = div_rsp.meta.base - ceil_q;
      end else begin
         hue_in = div_rsp.meta.base + {1'b0, div_rsp.hue_quo};
      end
      sat_in = div_rsp.meta.black ? 8'd0 : div_rsp.sat_quo;
   end

   always_comb begin
      pass[0] = !cfg.care[0] || lies_between(hue_ff, cfg.hue_a, cfg.hue_b);
      pass[1] = !cfg.care[1] ||
                lies_between({1'b0, sat_ff}, {1'b0, cfg.sat_a}, {1'b0, cfg.sat_b});
      pass[2] = !cfg.care[2] ||
                lies_between({1'b0, light_ff}, {1'b0, cfg.light_a}, {1'b0, cfg.light_b});
      out_range_in = (&pass) ^ cfg.invert;
   end

   always_ff @(posedge clock) begin
      if (fin_en) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= div_rsp.meta.light;
      end
      if (out_en) begin
         out_hue_ff   <= hue_ff;
         out_sat_ff   <= sat_ff;
         out_light_ff <= light_ff;
         out_range_ff <= out_range_in;
      end
   end

   assign hue        = out_hue_ff;
   assign saturation = out_sat_ff;
   assign lightness  = out_light_ff;
   assign in_range   = out_range_ff;

endmodule

// ----- sim/rgb_to_hsl_range_mask_test.sv -----
`timescale 1ns / 100ps

module rgb_to_hsl_range_mask_test;
   import hslm_pkg::*;

   localparam int unsigned StallLimit  = 2000;
   localparam int unsigned MaxPrinted  = 40;
   localparam int unsigned RandPhases  = 10;
   localparam int unsigned PhaseItems  = 55;

   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] lightness;
      logic       in_range;
   } hsl_pixel_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_red = '0;
   logic [7:0] req_green = '0;
   logic [7:0] req_blue = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [8:0] rsp_hue;
   logic [7:0] rsp_saturation;
   logic [7:0] rsp_lightness;
   logic       rsp_in_range;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [8:0] csr_wdata = '0;

   cfg_type       shadow_cfg;
   hsl_pixel_type hsl_expected[$];

   bit          req_gaps_on = 1'b1;
   bit          rsp_stalls_on = 1'b1;
   int unsigned stall_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned pixels_sent = 0;
   int unsigned results_checked = 0;
   int unsigned mask_set_count = 0;
   int unsigned setting_count = 0;
   int unsigned mismatch_count = 0;

   rgb_to_hsl_range_mask dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness),
      .rsp_in_range   (rsp_in_range),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit lies_between(int x, int a, int b);
      return (x >= a && x <= b) || (x >= b && x <= a);
   endfunction

   function automatic hsl_pixel_type predict_hsl(logic [7:0] r8, logic [7:0] g8,
                                                 logic [7:0] b8);
      int r, g, b, mx, mn, d, base, n, num, hue, sat, light;
      bit pass;
      hsl_pixel_type res;
      r = r8;
      g = g8;
      b = b8;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      if (d == 0) begin
         hue = 0;
      end else begin
         // first channel at the maximum picks the sector
         if (r == mx) begin
            base = 0;
            n = g - b;
         end else if (g == mx) begin
            base = 120;
            n = b - r;
         end else begin
            base = 240;
            n = r - g;
         end
         num = base * d + 60 * n;
         if (num < 0) num += 360 * d;
         hue = num / d;
      end
      sat = (mx == 0) ? 0 : (255 * d) / mx;
      light = (mx + mn) / 2;
      pass = 1'b1;
      if (shadow_cfg.care[0] && !lies_between(hue, shadow_cfg.hue_a, shadow_cfg.hue_b))
         pass = 1'b0;
      if (shadow_cfg.care[1] && !lies_between(sat, shadow_cfg.sat_a, shadow_cfg.sat_b))
         pass = 1'b0;
      if (shadow_cfg.care[2] &&
          !lies_between(light, shadow_cfg.light_a, shadow_cfg.light_b))
         pass = 1'b0;
      res.hue = hue[8:0];
      res.saturation = sat[7:0];
      res.lightness = light[7:0];
      res.in_range = pass ^ shadow_cfg.invert;
      return res;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      mismatch_count++;
      if (mismatch_count <= MaxPrinted)
         $display("%0t: %s mismatch on result %0d: got %0d, want %0d",
                  $realtime, field, results_checked, got, want);
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_red = r;
      req_green = g;
      req_blue = b;
      req_valid = 1'b1;
      // hold the item until it is taken
      do @(posedge clock); while (req_stall);
      hsl_expected.push_back(predict_hsl(r, g, b));
      pixels_sent++;
   endtask

   task automatic send_random_pixel;
      logic [7:0] r, g, b, v;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      v = 8'($urandom_range(0, 255));
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case (kind)
         0: begin
            r = v;
            g = v;
            b = v;
         end
         1: begin
            // two channels tie at the maximum
            r = $urandom_range(0, 1) ? 8'd255 : v;
            g = r;
            b = 8'($urandom_range(0, r));
            if ($urandom_range(0, 1)) begin
               g = b;
               b = r;
            end
         end
         2: begin
            r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   // drop valid and wait until every result is back
   task automatic drain_pipeline;
      @(negedge clock);
      req_valid = 1'b0;
      while (hsl_expected.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [8:0] value);
      @(negedge clock);
      csr_index = idx;
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_HUE_A:   shadow_cfg.hue_a = value;
         REG_HUE_B:   shadow_cfg.hue_b = value;
         REG_SAT_A:   shadow_cfg.sat_a = value[7:0];
         REG_SAT_B:   shadow_cfg.sat_b = value[7:0];
         REG_LIGHT_A: shadow_cfg.light_a = value[7:0];
         REG_LIGHT_B: shadow_cfg.light_b = value[7:0];
         REG_CARE:    shadow_cfg.care = value[2:0];
         REG_INVERT:  shadow_cfg.invert = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [8:0] ha, logic [8:0] hb, logic [8:0] sa,
                               logic [8:0] sb, logic [8:0] la, logic [8:0] lb,
                               logic [8:0] care, logic [8:0] inv);
      write_reg(REG_HUE_A, ha);
      write_reg(REG_HUE_B, hb);
      write_reg(REG_SAT_A, sa);
      write_reg(REG_SAT_B, sb);
      write_reg(REG_LIGHT_A, la);
      write_reg(REG_LIGHT_B, lb);
      write_reg(REG_CARE, care);
      write_reg(REG_INVERT, inv);
      @(negedge clock);
      csr_valid = 1'b0;
      setting_count++;
   endtask

   task automatic send_random_burst(int unsigned count);
      repeat (count) send_random_pixel();
      drain_pipeline();
   endtask

   task automatic test_reset_defaults;
      logic [23:0] corners[16];
      corners = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
                  24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                  24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'h010000,
                  24'hFFFEFE, 24'h00FF01, 24'h0100FF, 24'h7F3AC9};
      setting_count++;
      foreach (corners[i]) send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);
      drain_pipeline();
   endtask

   task automatic test_bound_extremes;
      // every bound at zero: only black passes
      apply_config(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd7, 9'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_random_burst(20);
      apply_config(9'd359, 9'd359, 9'd255, 9'd255, 9'd255, 9'd255, 9'd7, 9'd1);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_random_burst(20);
      // bounds given high to low
      apply_config(9'd300, 9'd60, 9'd200, 9'd50, 9'd180, 9'd20, 9'd7, 9'd0);
      send_random_burst(20);
      // hue bounds past 359 widen or empty the range
      apply_config(9'd511, 9'd300, 9'd0, 9'd255, 9'd0, 9'd255, 9'd1, 9'd0);
      send_random_burst(20);
      apply_config(9'd400, 9'd511, 9'd0, 9'd0, 9'd0, 9'd0, 9'd1, 9'd1);
      send_random_burst(20);
      // nothing cared for
      apply_config(9'd10, 9'd20, 9'd10, 9'd20, 9'd10, 9'd20, 9'd0, 9'd0);
      send_random_burst(20);
      apply_config(9'd10, 9'd20, 9'd10, 9'd20, 9'd10, 9'd20, 9'd0, 9'd1);
      send_random_burst(20);
   endtask

   task automatic test_register_masking;
      // upper bits beyond each register width must be dropped
      apply_config(9'h1FF, 9'h0B4, 9'h140, 9'h1C0, 9'h11F, 9'h1F0, 9'h1FB, 9'h1FE);
      send_random_burst(20);
      apply_config(9'h000, 9'h167, 9'h100, 9'h1FF, 9'h100, 9'h1FF, 9'h1FF, 9'h1FF);
      send_random_burst(20);
   endtask

   task automatic test_random_phases;
      logic [8:0] bounds[6];
      int unsigned mode;
      for (int p = 0; p < RandPhases; p++) begin
         foreach (bounds[i])
            bounds[i] = (i < 2) ?
                        9'($urandom_range(0, $urandom_range(0, 7) == 0 ? 511 : 359)) :
                        9'($urandom_range(0, 511));
         apply_config(bounds[0], bounds[1], bounds[2], bounds[3], bounds[4], bounds[5],
                      9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
         mode = $urandom_range(0, 3);
         req_gaps_on = mode[0];
         rsp_stalls_on = mode[1];
         send_random_burst(PhaseItems);
      end
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // result side: draw a stall length per item
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      hsl_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hsl_expected.size() == 0) begin
            report_mismatch("unexpected result, hue", rsp_hue, 0);
         end else begin
            want = hsl_expected.pop_front();
            if (rsp_hue !== want.hue) report_mismatch("hue", rsp_hue, want.hue);
            if (rsp_saturation !== want.saturation)
               report_mismatch("saturation", rsp_saturation, want.saturation);
            if (rsp_lightness !== want.lightness)
               report_mismatch("lightness", rsp_lightness, want.lightness);
            if (rsp_in_range !== want.in_range)
               report_mismatch("in_range", rsp_in_range, want.in_range);
         end
         if (rsp_in_range === 1'b1) mask_set_count++;
         results_checked++;
         stall_left = rsp_stalls_on ? $urandom_range(0, 5) : 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      shadow_cfg = '{hue_a: 9'd0, hue_b: 9'd359, sat_a: 8'd0, sat_b: 8'd255,
                     light_a: 8'd0, light_b: 8'd255, care: 3'd7, invert: 1'b0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_bound_extremes();
      test_register_masking();
      test_random_phases();

      drain_pipeline();
      repeat (NumStages + 4) @(negedge clock);

      $display("Sent %0d pixels under %0d register settings; %0d results checked, %0d in range.",
               pixels_sent, setting_count, results_checked, mask_set_count);
      $display("Mismatches found: %0d", mismatch_count);
      if (mismatch_count == 0 && hsl_expected.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
sv/hslm_pkg.sv
sv/hslm_csr.sv
sv/hslm_front.sv
sv/hslm_div.sv
sv/hslm_back.sv
sv/rgb_to_hsl_range_mask.sv
sim/rgb_to_hsl_range_mask_test.sv
